// ===== design/tpsw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpsw_pkg
// Shared codes, types and fixed widths of the square wave / PWM generator.
// ----------------------------------------------------------------------------
package tpsw_pkg;

  // Fixed field widths
  localparam int CFG_W    = 32;
  localparam int DUTY_W   = 17;
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 2;

  // Start-up wait is clock_hz divided by this
  localparam int WAIT_DIV = 100;

  // Reciprocal of WAIT_DIV: (x * WAIT_MUL) >> WAIT_SHIFT == x / 100 for any 32-bit x
  localparam logic [CFG_W-1:0] WAIT_MUL   = 32'h51EB_851F;
  localparam int               WAIT_SHIFT = 37;

  // Register reset values
  localparam logic [CFG_W-1:0]  CLOCK_HZ_RST = 32'd200000000;
  localparam logic [CFG_W-1:0]  OUT_FREQ_RST = 32'd1000;
  localparam logic [DUTY_W-1:0] DUTY_RST     = 17'd32768;

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_code_t;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_CLOCK_HZ = 2'd0,
    CFG_OUT_FREQ = 2'd1,
    CFG_DUTY     = 2'd2
  } cfg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_PER,
    ST_LOAD_WAIT,
    ST_MUL_INIT,
    ST_MUL,
    ST_DONE
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic apply;     // execute tick / stop / unknown item
    logic start;     // begin start: save pin, load period division
    logic div_step;  // one restoring division step
    logic per_load;  // store period and start-up wait
    logic mul_init;  // load duty multiplication
    logic mul_step;  // one shift-add step
    logic finish;    // store phase lengths, emit start result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_valid;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== design/tpsw_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpsw_ctrl
// Sequencer: takes items, steps the divider and the shift-add
// multiplier through the start calculation.
// ----------------------------------------------------------------------------
module tpsw_ctrl
  import tpsw_pkg::*;
#(
  parameter int DUTY_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [CMD_W-1:0] in_command,
  input  wire logic             out_ready,
  input  wire dp_stat_t         stat,
  output logic                  in_ready,
  output dp_cmd_t               cmd
);

  localparam int DIV_STEPS = CFG_W;
  localparam int MUL_STEPS = DUTY_BITS + 1;
  localparam int STEP_MAX  = (DIV_STEPS > MUL_STEPS) ? DIV_STEPS : MUL_STEPS;
  localparam int STEP_W    = $clog2(STEP_MAX);

  ctrl_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              accept;
  logic              is_start;

  // Take a beat only when idle and the result slot frees up
  assign in_ready = (state_r == ST_IDLE) && (!stat.out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_start = (in_command == CMD_START);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (accept && is_start) state_nxt = ST_DIV_PER;
      ST_DIV_PER:   if (step_r == '0) state_nxt = ST_LOAD_WAIT;
      ST_LOAD_WAIT: state_nxt = ST_MUL_INIT;
      ST_MUL_INIT:  state_nxt = ST_MUL;
      ST_MUL:       if (step_r == '0) state_nxt = ST_DONE;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Step counter: load at each unit start, count down while it runs
  always_comb begin
    step_nxt = step_r;
    case (state_r)
      ST_IDLE:      step_nxt = STEP_W'(DIV_STEPS - 1);
      ST_MUL_INIT:  step_nxt = STEP_W'(MUL_STEPS - 1);
      ST_DIV_PER, ST_MUL: begin
        if (step_r != '0) step_nxt = step_r - 1'b1;
      end
      default:      step_nxt = step_r;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.apply = accept && !is_start;
        cmd.start = accept && is_start;
      end
      ST_DIV_PER:   cmd.div_step = 1'b1;
      ST_LOAD_WAIT: cmd.per_load = 1'b1;
      ST_MUL_INIT:  cmd.mul_init = 1'b1;
      ST_MUL:       cmd.mul_step = 1'b1;
      ST_DONE:      cmd.finish   = 1'b1;
      default:      cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
  end

endmodule
`default_nettype wire

// ===== design/tpsw_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpsw_dp
// Datapath: config registers, waveform state, restoring divider,
// shift-add multiplier and the result register.
// ----------------------------------------------------------------------------
module tpsw_dp
  import tpsw_pkg::*;
#(
  parameter int COUNTER_WIDTH = 32,
  parameter int DUTY_BITS     = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic              in_pin_level_now,
  input  wire logic              out_ready,
  output logic                   out_pin_out,
  output logic                   out_running,
  output logic                   out_edge_res,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam int CW = COUNTER_WIDTH;
  localparam int DB = DUTY_BITS;
  localparam int PW = CW + DB + 1;
  localparam logic [63:0] CNT_MAX64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - CW);
  localparam logic [63:0] DUTY_FULL = 64'd1 << DB;

  // Clamp a 32-bit value to the counter range
  function automatic logic [CW-1:0] sat_cnt(input logic [CFG_W-1:0] v);
    logic [63:0] v64;
    v64 = 64'(v);
    return (v64 > CNT_MAX64) ? CNT_MAX64[CW-1:0] : v64[CW-1:0];
  endfunction

  // Config registers
  logic [CFG_W-1:0]  clock_hz_r, clock_hz_nxt;
  logic [CFG_W-1:0]  out_freq_r, out_freq_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;

  // Waveform state
  logic          active_r, active_nxt;
  logic          level_r, level_nxt;
  logic          saved_r, saved_nxt;
  logic          edge_pend_r, edge_pend_nxt;
  logic [CW-1:0] countdown_r, countdown_nxt;
  logic [CW-1:0] high_r, high_nxt;
  logic [CW-1:0] low_r, low_nxt;

  // Divider
  logic [CFG_W-1:0] div_rem_r, div_rem_nxt;
  logic [CFG_W-1:0] div_q_r, div_q_nxt;
  logic [CFG_W-1:0] div_d_r, div_d_nxt;
  logic             div_zero_r, div_zero_nxt;
  logic [CFG_W:0]   rem_sh;
  logic [CFG_W:0]   rem_diff;

  // Start-up wait by reciprocal multiplication
  logic [2*CFG_W-1:0] wait_prod;
  logic [CFG_W-1:0]   wait_q;

  // Multiplier
  logic [CW-1:0] period_r, period_nxt;
  logic [PW-1:0] mul_acc_r, mul_acc_nxt;
  logic [PW-1:0] mul_mcand_r, mul_mcand_nxt;
  logic [DB:0]   mul_mplr_r, mul_mplr_nxt;
  logic [63:0]   duty64;
  logic [63:0]   duty_sat;
  logic [CW-1:0] high_val;

  // Result register
  logic out_valid_r, out_valid_nxt;
  logic out_pin_r, out_pin_nxt;
  logic out_run_r, out_run_nxt;
  logic out_edge_r, out_edge_nxt;

  // Tick / stop evaluation
  logic          t_active, t_level;
  logic [CW-1:0] t_count;
  logic [CW-1:0] cd_dec;
  logic [CW-1:0] next_len;
  logic [CW-1:0] same_len;

  assign rem_sh    = {div_rem_r, div_q_r[CFG_W-1]};
  assign rem_diff  = rem_sh - {1'b0, div_d_r};
  assign wait_prod = {{CFG_W{1'b0}}, clock_hz_r} * {{CFG_W{1'b0}}, WAIT_MUL};
  assign wait_q    = CFG_W'(wait_prod >> WAIT_SHIFT);
  assign duty64    = 64'(duty_r);
  assign duty_sat  = (duty64 > DUTY_FULL) ? DUTY_FULL : duty64;
  assign high_val  = mul_acc_r[DB +: CW];
  assign cd_dec    = (countdown_r != '0) ? countdown_r - 1'b1 : countdown_r;
  assign next_len  = level_r ? low_r : high_r;
  assign same_len  = level_r ? high_r : low_r;

  // Evaluate a tick, stop or unknown command against the present state
  always_comb begin
    t_active = active_r;
    t_level  = level_r;
    t_count  = countdown_r;
    case (in_command)
      CMD_TICK: begin
        if (active_r) begin
          t_count = cd_dec;
          if (cd_dec == '0) begin
            if (next_len != '0) begin
              t_level = !level_r;
              t_count = next_len;
            end else if (same_len != '0) begin
              t_count = same_len;
            end else begin
              t_level = 1'b0;
              t_count = '0;
            end
          end
        end
      end
      CMD_STOP: begin
        if (active_r) begin
          t_active = 1'b0;
          t_level  = saved_r;
          t_count  = '0;
        end
      end
      default: begin
        t_active = active_r;
      end
    endcase
  end

  // Next values
  always_comb begin
    clock_hz_nxt  = clock_hz_r;
    out_freq_nxt  = out_freq_r;
    duty_nxt      = duty_r;
    active_nxt    = active_r;
    level_nxt     = level_r;
    saved_nxt     = saved_r;
    edge_pend_nxt = edge_pend_r;
    countdown_nxt = countdown_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    div_rem_nxt   = div_rem_r;
    div_q_nxt     = div_q_r;
    div_d_nxt     = div_d_r;
    div_zero_nxt  = div_zero_r;
    period_nxt    = period_r;
    mul_acc_nxt   = mul_acc_r;
    mul_mcand_nxt = mul_mcand_r;
    mul_mplr_nxt  = mul_mplr_r;
    out_pin_nxt   = out_pin_r;
    out_run_nxt   = out_run_r;
    out_edge_nxt  = out_edge_r;
    out_valid_nxt = out_valid_r && !out_ready;

    // Write config
    if (cfg_we) begin
      case (cfg_index)
        CFG_CLOCK_HZ: clock_hz_nxt = cfg_wdata;
        CFG_OUT_FREQ: out_freq_nxt = cfg_wdata;
        CFG_DUTY:     duty_nxt     = cfg_wdata[DUTY_W-1:0];
        default:      clock_hz_nxt = clock_hz_r;
      endcase
    end

    // Tick, stop or unknown item: update state and post the result
    if (cmd.apply) begin
      active_nxt    = t_active;
      level_nxt     = t_level;
      countdown_nxt = t_count;
      out_valid_nxt = 1'b1;
      out_pin_nxt   = t_level;
      out_run_nxt   = t_active;
      out_edge_nxt  = t_level != level_r;
    end

    // Start: restore-then-restart collapses to pin low, save pin, divide period
    if (cmd.start) begin
      edge_pend_nxt = level_r;
      saved_nxt     = in_pin_level_now;
      level_nxt     = 1'b0;
      active_nxt    = 1'b1;
      div_rem_nxt   = '0;
      div_q_nxt     = clock_hz_r;
      div_d_nxt     = out_freq_r;
      div_zero_nxt  = (out_freq_r == '0);
    end

    // Advance one quotient bit
    if (cmd.div_step) begin
      if (!rem_diff[CFG_W]) begin
        div_rem_nxt = rem_diff[CFG_W-1:0];
        div_q_nxt   = {div_q_r[CFG_W-2:0], 1'b1};
      end else begin
        div_rem_nxt = rem_sh[CFG_W-1:0];
        div_q_nxt   = {div_q_r[CFG_W-2:0], 1'b0};
      end
    end

    // Hold period, load the start-up wait into the countdown
    if (cmd.per_load) begin
      period_nxt    = div_zero_r ? '0 : sat_cnt(div_q_r);
      countdown_nxt = sat_cnt(wait_q);
    end

    // Load the duty product
    if (cmd.mul_init) begin
      mul_acc_nxt   = '0;
      mul_mcand_nxt = PW'(period_r);
      mul_mplr_nxt  = duty_sat[DB:0];
    end

    // Add one partial product
    if (cmd.mul_step) begin
      if (mul_mplr_r[0]) mul_acc_nxt = mul_acc_r + mul_mcand_r;
      mul_mcand_nxt = {mul_mcand_r[PW-2:0], 1'b0};
      mul_mplr_nxt  = {1'b0, mul_mplr_r[DB:1]};
    end

    // Store phase lengths and post the start result
    if (cmd.finish) begin
      high_nxt      = high_val;
      low_nxt       = period_r - high_val;
      out_valid_nxt = 1'b1;
      out_pin_nxt   = 1'b0;
      out_run_nxt   = 1'b1;
      out_edge_nxt  = edge_pend_r;
    end
  end

  // Control state and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r  <= CLOCK_HZ_RST;
      out_freq_r  <= OUT_FREQ_RST;
      duty_r      <= DUTY_RST;
      active_r    <= 1'b0;
      level_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clock_hz_r  <= clock_hz_nxt;
      out_freq_r  <= out_freq_nxt;
      duty_r      <= duty_nxt;
      active_r    <= active_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    saved_r     <= saved_nxt;
    edge_pend_r <= edge_pend_nxt;
    countdown_r <= countdown_nxt;
    high_r      <= high_nxt;
    low_r       <= low_nxt;
    div_rem_r   <= div_rem_nxt;
    div_q_r     <= div_q_nxt;
    div_d_r     <= div_d_nxt;
    div_zero_r  <= div_zero_nxt;
    period_r    <= period_nxt;
    mul_acc_r   <= mul_acc_nxt;
    mul_mcand_r <= mul_mcand_nxt;
    mul_mplr_r  <= mul_mplr_nxt;
    out_pin_r   <= out_pin_nxt;
    out_run_r   <= out_run_nxt;
    out_edge_r  <= out_edge_nxt;
  end

  assign stat.out_valid = out_valid_r;
  assign out_pin_out    = out_pin_r;
  assign out_running    = out_run_r;
  assign out_edge_res   = out_edge_r;

endmodule
`default_nettype wire

// ===== design/timer_pwm_square_wave_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timer_pwm_square_wave_core
// Single-channel square wave / PWM generator stepped by timer ticks.
// ----------------------------------------------------------------------------
// Each input beat is a tick, start or stop command and yields one result beat.
// Tick, stop and unknown commands are applied directly; such beats are taken on
// consecutive cycles as long as the result side keeps up. For a start, the
// one-bit-per-cycle restoring divider forms the period clock_hz / out_freq_hz,
// the start-up wait clock_hz / 100 comes from a reciprocal multiplication as
// the period is stored, then the shift-add multiplier forms the high phase one
// duty bit per cycle. No input is taken during that sequence. Config writes
// take effect at the next start.
module timer_pwm_square_wave_core
  import tpsw_pkg::*;
#(
  parameter int COUNTER_WIDTH = 32,
  parameter int DUTY_BITS     = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CMD_W-1:0] in_command,
  input  wire logic             in_pin_level_now,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_pin_out,
  output logic                  out_running,
  output logic                  out_edge_res,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  tpsw_ctrl #(
    .DUTY_BITS (DUTY_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .out_ready  (out_ready),
    .stat       (stat),
    .in_ready   (in_ready),
    .cmd        (cmd)
  );

  // Datapath
  tpsw_dp #(
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .DUTY_BITS     (DUTY_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_command       (in_command),
    .in_pin_level_now (in_pin_level_now),
    .out_ready        (out_ready),
    .out_pin_out      (out_pin_out),
    .out_running      (out_running),
    .out_edge_res     (out_edge_res),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  assign out_valid = stat.out_valid;

  // A start beat blocks input and has no result on the following cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command == CMD_START) |=> (!in_ready && !out_valid))
    else $error("start beat did not enter the calculation sequence");

  // A single-cycle command posts its result on the next cycle
  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command != CMD_START) |=> out_valid)
    else $error("tick or stop beat produced no result");

  // Input is taken only when the result slot is free or draining
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("input taken while result slot is stalled");

endmodule
`default_nettype wire

// ===== tb/pwm_wave_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwm_wave_checker
// Watches the command and result channels of the square wave generator,
// tracks the register writes, predicts every result beat and compares it.
// ----------------------------------------------------------------------------
module pwm_wave_checker
  import tpsw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_ready,
  input  wire logic [CMD_W-1:0] in_command,
  input  wire logic             in_pin_level_now,
  input  wire logic             out_valid,
  input  wire logic             out_ready,
  input  wire logic             out_pin_out,
  input  wire logic             out_running,
  input  wire logic             out_edge_res,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int              CNT_W     = 32;
  localparam int              FRAC_W    = 16;
  localparam logic [63:0]     FULL_DUTY = 64'd1 << FRAC_W;

  typedef struct packed {
    logic pin_out;
    logic running;
    logic edge_res;
  } wave_beat_t;

  // Shadow registers
  logic [CFG_W-1:0]  clock_hz_r;
  logic [CFG_W-1:0]  out_freq_r;
  logic [DUTY_W-1:0] duty_r;

  // Predicted generator state
  logic              on_q;
  logic              level_q;
  logic              saved_q;
  logic [CNT_W-1:0]  remain_q;
  logic [CNT_W-1:0]  high_len;
  logic [CNT_W-1:0]  low_len;

  wave_beat_t        wave_due_q[$];
  int                miss_n = 0;

  // Drop the wave and put the saved level back on the pin
  function automatic void halt_wave();
    if (on_q) begin
      on_q     = 1'b0;
      level_q  = saved_q;
      remain_q = '0;
    end
  endfunction

  // Advance the predicted state by one command beat
  function automatic wave_beat_t step_wave(logic [CMD_W-1:0] cmd, logic pin);
    logic             was;
    logic [63:0]      period;
    logic [63:0]      frac;
    logic [63:0]      hi;
    logic [CNT_W-1:0] next_len;
    logic [CNT_W-1:0] same_len;
    wave_beat_t       res;
    was = level_q;
    case (cmd)
      CMD_TICK: begin
        if (on_q) begin
          if (remain_q != 0) remain_q = remain_q - 1'b1;
          if (remain_q == 0) begin
            next_len = level_q ? low_len : high_len;
            same_len = level_q ? high_len : low_len;
            if (next_len != 0) begin
              level_q  = ~level_q;
              remain_q = next_len;
            end else if (same_len != 0) begin
              // empty next phase: hold the level for another phase
              remain_q = same_len;
            end else begin
              level_q  = 1'b0;
              remain_q = '0;
            end
          end
        end
      end
      CMD_START: begin
        halt_wave();
        saved_q  = pin;
        period   = (out_freq_r != 0) ? 64'(clock_hz_r / out_freq_r) : 64'd0;
        frac     = (64'(duty_r) > FULL_DUTY) ? FULL_DUTY : 64'(duty_r);
        hi       = (period * frac) >> FRAC_W;
        high_len = hi[CNT_W-1:0];
        low_len  = period[CNT_W-1:0] - high_len;
        remain_q = clock_hz_r / CFG_W'(WAIT_DIV);
        level_q  = 1'b0;
        on_q     = 1'b1;
      end
      CMD_STOP: halt_wave();
      default: ;
    endcase
    res.pin_out  = level_q;
    res.running  = on_q;
    res.edge_res = (level_q != was);
    return res;
  endfunction

  // Compare result beats, queue predictions, track register writes
  always @(posedge clk) begin
    wave_beat_t due;
    if (!rst_n) begin
      clock_hz_r = CLOCK_HZ_RST;
      out_freq_r = OUT_FREQ_RST;
      duty_r     = DUTY_RST;
      on_q       = 1'b0;
      level_q    = 1'b0;
      saved_q    = 1'b0;
      remain_q   = '0;
      high_len   = '0;
      low_len    = '0;
      wave_due_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (wave_due_q.size() == 0) begin
          $error("result beat with no prediction waiting");
          miss_n++;
        end else begin
          due = wave_due_q.pop_front();
          if (out_pin_out !== due.pin_out) begin
            $error("pin_out: expected %0d, got %0d", due.pin_out, out_pin_out);
            miss_n++;
          end
          if (out_running !== due.running) begin
            $error("running: expected %0d, got %0d", due.running, out_running);
            miss_n++;
          end
          if (out_edge_res !== due.edge_res) begin
            $error("edge_res: expected %0d, got %0d", due.edge_res, out_edge_res);
            miss_n++;
          end
        end
      end
      if (in_valid && in_ready) begin
        wave_due_q.push_back(step_wave(in_command, in_pin_level_now));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLOCK_HZ: clock_hz_r = cfg_wdata;
          CFG_OUT_FREQ: out_freq_r = cfg_wdata;
          CFG_DUTY:     duty_r     = cfg_wdata[DUTY_W-1:0];
          default: ;
        endcase
      end
    end
    pending    <= wave_due_q.size();
    fail_count <= miss_n;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives commands and register settings into the square wave generator,
// with random gaps and result stalls; the checker judges every result beat.
// ----------------------------------------------------------------------------
module tb;
  import tpsw_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int               RAND_BEATS = 800;

  logic             clk              = 1'b0;
  logic             rst_n            = 1'b0;
  logic             in_valid         = 1'b0;
  logic [CMD_W-1:0] in_command       = CMD_TICK;
  logic             in_pin_level_now = 1'b0;
  logic             out_ready        = 1'b0;
  logic             cfg_we           = 1'b0;
  logic [IDX_W-1:0] cfg_index        = CFG_CLOCK_HZ;
  logic [CFG_W-1:0] cfg_wdata        = '0;

  wire logic        in_ready;
  wire logic        out_valid;
  wire logic        out_pin_out;
  wire logic        out_running;
  wire logic        out_edge_res;

  int               fail_count;
  int               pending;
  int               beats_sent = 0;
  logic             hold_out   = 1'b0;
  wire logic        calm       = (beats_sent >= 500) && (beats_sent < 650);

  timer_pwm_square_wave_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_pin_level_now (in_pin_level_now),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pin_out      (out_pin_out),
    .out_running      (out_running),
    .out_edge_res     (out_edge_res),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  pwm_wave_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_pin_level_now (in_pin_level_now),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pin_out      (out_pin_out),
    .out_running      (out_running),
    .out_edge_res     (out_edge_res),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random stalls, none in the calm stretch, stalled throughout while held
  always @(posedge clk) begin
    if (!rst_n || hold_out) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 28);
    end
  end

  // Hold results back long enough to back the block up into its input
  initial begin
    wait (beats_sent >= 300);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (300) @(posedge clk);
    hold_out <= 1'b0;
  end

  // Offer one command beat, with random gaps ahead of it
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic pin);
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_pin_level_now <= pin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent <= beats_sent + 1;
  endtask

  // Drop valid and wait until every predicted beat has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers once the block has drained
  task automatic load_regs(input logic [CFG_W-1:0] hz, input logic [CFG_W-1:0] freq,
                           input logic [CFG_W-1:0] duty_word);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CLOCK_HZ;
    cfg_wdata <= hz;
    @(posedge clk);
    cfg_index <= CFG_OUT_FREQ;
    cfg_wdata <= freq;
    @(posedge clk);
    cfg_index <= CFG_DUTY;
    cfg_wdata <= duty_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] hz;
    logic [CFG_W-1:0] freq;
    logic [CFG_W-1:0] duty_word;
    int               pick;
    int               roll;
    int               n;
    int               k;
    int               rand_n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Idle block: tick, stop and unknown code change nothing
    send_beat(CMD_TICK, 1'b1);
    send_beat(CMD_STOP, 1'b0);
    send_beat(CMD_UNUSED, 1'b1);
    // Reset rates: start, restart while running, stop restores the pin
    send_beat(CMD_START, 1'b1);
    send_beat(CMD_TICK, 1'b0);
    send_beat(CMD_START, 1'b0);
    send_beat(CMD_UNUSED, 1'b0);
    send_beat(CMD_STOP, 1'b1);
    // No start-up wait, empty high phase
    load_regs(32'd50, 32'd10, 32'd0);
    send_beat(CMD_START, 1'b1);
    repeat (6) send_beat(CMD_TICK, 1'b0);
    send_beat(CMD_STOP, 1'b0);
    // Duty above full scale, empty low phase
    load_regs(32'd99, 32'd1, 32'h0001_FFFF);
    send_beat(CMD_START, 1'b0);
    repeat (3) send_beat(CMD_TICK, 1'b1);
    // Zero frequency gives a zero period
    load_regs(32'd80, 32'd0, 32'd65536);
    send_beat(CMD_START, 1'b1);
    repeat (2) send_beat(CMD_TICK, 1'b0);
    // Widest register values
    load_regs(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
    send_beat(CMD_START, 1'b1);
    send_beat(CMD_TICK, 1'b1);
    send_beat(CMD_STOP, 1'b0);

    // Random settings, each followed by a run of commands
    rand_n = 0;
    while (rand_n < RAND_BEATS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      hz = $urandom_range(0, 99);
      else if (pick == 8) hz = $urandom();
      else if (pick == 9) hz = 32'hFFFF_FFFF;
      else                hz = $urandom_range(100, 3000);

      pick = $urandom_range(0, 9);
      if (pick == 0)      freq = '0;
      else if (pick == 1) freq = hz + $urandom_range(1, 1000);
      else if (pick == 2) freq = $urandom();
      else begin
        freq = hz / $urandom_range(1, 40);
        if (freq == 0) freq = 32'd1;
      end

      pick = $urandom_range(0, 9);
      if (pick == 0)      duty_word = 32'd0;
      else if (pick == 1) duty_word = 32'd65536;
      else if (pick == 2) duty_word = $urandom_range(65537, 131071);
      else                duty_word = $urandom_range(0, 65535);
      // upper bits beyond the duty field are don't-care
      if ($urandom_range(0, 3) == 0) duty_word = duty_word | ($urandom() & 32'hFFFE_0000);

      load_regs(hz, freq, duty_word);
      n = (hz > 32'd10000) ? $urandom_range(3, 8) : $urandom_range(20, 60);
      for (k = 0; k < n; k++) begin
        roll = $urandom_range(0, 99);
        if (k == 0 || roll < 4)  send_beat(CMD_START, 1'($urandom()));
        else if (roll < 10)      send_beat(CMD_STOP, 1'($urandom()));
        else if (roll < 13)      send_beat(CMD_UNUSED, 1'($urandom()));
        else                     send_beat(CMD_TICK, 1'($urandom()));
        rand_n++;
      end
    end

    // Drain, let the block settle, then give the verdict
    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("timer_pwm_square_wave_core: match");
    end else begin
      $display("timer_pwm_square_wave_core: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("timer_pwm_square_wave_core: mismatch");
    $finish;
  end

endmodule
